// ----- rtl/core/heap_sorter_core_assert.svh -----
// Assertion macros shared by the heap sorter modules.
// Needs clk and rst_n in the scope of each use.
`ifndef HEAP_SORTER_CORE_ASSERT_SVH
`define HEAP_SORTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define HS_ASSERT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heap sorter assertion failed");

// Next-cycle implication, disabled while in reset.
`define HS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heap sorter assertion failed");

`endif

// ----- rtl/core/hs_pkg.sv -----
// Shared types and constants for the heap sorter.
// No dependencies; used by every module of the block.
package hs_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FIELD_W        = 32;

    typedef struct packed {
        logic signed [FIELD_W-1:0] data_value;
        logic                      last_element;
    } in_item_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] sorted_value;
        logic                      last_result;
        logic                      overflow_flag;
    } out_item_t;

    // Controller to datapath commands, at most one per cycle.
    typedef struct packed {
        logic load;        // store the accepted item, or flag overflow if full
        logic build_rd;    // fetch the next heapify root
        logic build_fetch; // latch heapify root as sifting value
        logic sift_rd;     // read both children of the current node, or write back at a leaf
        logic sift_cmp;    // compare and write one level
        logic extr_init;   // load the extraction counter
        logic extr_rd;     // read root and heap tail
        logic extr_swap;   // move root to tail, start sift from root
        logic out_first;   // read first sorted element
        logic out_adv;     // result transfer done
    } hs_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic k_zero;   // no heapify roots left
        logic k_le1;    // extraction finished
        logic leaf;     // current node has no child in the heap
        logic move;     // larger child beats the sifting value
        logic out_last; // current result is the final one
    } hs_status_t;

endpackage

// ----- rtl/core/heap_sorter_core.sv -----
// Top level of the heap sorter: controller plus datapath.
// Depends on hs_pkg, hs_ctrl and hs_datapath.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------------
//  in      | into core | in_valid / in_ready   | data_value, last_element
//  out     | out of it | out_valid / out_ready | sorted_value, last_result, overflow_flag
//
// Loading accepts one input transfer per cycle. The transfer marked last starts
// the sort; input stays stalled until the final result transfer of the run.
// Each sift level is a two-port child read, then a compare and one write into
// the element memory. Results then leave one per cycle while out_ready is high.
// Reset leaves the store empty; memory contents need no clearing.
// A stalled result holds its payload; nothing else moves meanwhile.

module heap_sorter_core #(
    parameter int CAPACITY   = hs_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = hs_pkg::DATA_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  hs_pkg::in_item_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output hs_pkg::out_item_t out_data
);

    hs_pkg::hs_cmd_t    cmd;
    hs_pkg::hs_status_t status;

    // Sequence the phases; issue at most one command per cycle.
    hs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_last   (in_data.last_element),
        .out_ready (out_ready),
        .status    (status),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    // Hold the elements, run the sift steps, drive the result payload.
    hs_datapath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .status   (status),
        .out_data (out_data)
    );

endmodule

// ----- rtl/core/hs_datapath.sv -----
// Datapath of the heap sorter: element memory, sift unit, counters.
// Depends on hs_pkg and heap_sorter_core_assert.svh.
`include "heap_sorter_core_assert.svh"

module hs_datapath #(
    parameter int CAPACITY   = hs_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = hs_pkg::DATA_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  hs_pkg::hs_cmd_t    cmd,
    input  hs_pkg::in_item_t   in_data,
    output hs_pkg::hs_status_t status,
    output hs_pkg::out_item_t  out_data
);

    localparam int ADDR_W  = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int CHILD_W = CNT_W + 1;
    localparam int EXT_W   = (DATA_WIDTH > hs_pkg::FIELD_W) ? DATA_WIDTH : hs_pkg::FIELD_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [DATA_WIDTH-1:0] mem [CAPACITY];
    logic [DATA_WIDTH-1:0] rd_a_reg;
    logic [DATA_WIDTH-1:0] rd_b_reg;
    logic [DATA_WIDTH-1:0] v_reg;
    logic [DATA_WIDTH-1:0] v_next;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic              dropped_reg, dropped_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  heap_len_reg, heap_len_next;
    logic [ADDR_W-1:0] node_reg, node_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              rc_ok_reg, rc_ok_next;

    logic [EXT_W-1:0]      ext_in;
    logic [EXT_W-1:0]      ext_out;
    logic [DATA_WIDTH-1:0] store_val;
    logic                  full;
    logic [CNT_W-1:0]      count_inc;
    logic [CNT_W-1:0]      k_dec;
    logic [ADDR_W-1:0]     k_addr;
    logic [CHILD_W-1:0]    lc;
    logic [CHILD_W-1:0]    rc;
    logic [CHILD_W-1:0]    heap_ext;
    logic                  leaf;
    logic                  rc_ok;
    logic                  best_is_r;
    logic [DATA_WIDTH-1:0] best_val;
    logic [ADDR_W-1:0]     best_idx;
    logic                  move;
    logic                  out_last;

    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  rd_a_en;
    logic [ADDR_W-1:0]     rd_a_addr;
    logic                  rd_b_en;
    logic [ADDR_W-1:0]     rd_b_addr;

    assign ext_in    = EXT_W'($unsigned(in_data.data_value));
    assign store_val = ext_in[DATA_WIDTH-1:0];
    assign full      = (count_reg == CAP_CNT);
    assign count_inc = count_reg + CNT_W'(1);
    assign k_dec     = k_reg - CNT_W'(1);
    assign k_addr    = k_dec[ADDR_W-1:0];

    assign lc       = CHILD_W'({node_reg, 1'b1});
    assign rc       = CHILD_W'({node_reg, 1'b0}) + CHILD_W'(2);
    assign heap_ext = CHILD_W'(heap_len_reg);
    assign leaf     = (lc >= heap_ext);
    assign rc_ok    = (rc < heap_ext);

    // Larger child wins; right only if strictly greater.
    assign best_is_r = rc_ok_reg && ($signed(rd_b_reg) > $signed(rd_a_reg));
    assign best_val  = best_is_r ? rd_b_reg : rd_a_reg;
    assign best_idx  = best_is_r ? rc[ADDR_W-1:0] : lc[ADDR_W-1:0];
    assign move      = ($signed(best_val) > $signed(v_reg));

    assign out_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    always_comb
    begin
        wr_en     = 1'b0;
        wr_addr   = '0;
        wr_data   = v_reg;
        rd_a_en   = 1'b0;
        rd_a_addr = '0;
        rd_b_en   = 1'b0;
        rd_b_addr = '0;
        if (cmd.load && !full)
        begin
            wr_en   = 1'b1;
            wr_addr = count_reg[ADDR_W-1:0];
            wr_data = store_val;
        end
        if (cmd.build_rd)
        begin
            rd_a_en   = 1'b1;
            rd_a_addr = k_addr;
        end
        if (cmd.sift_rd)
        begin
            if (leaf)
            begin
                wr_en   = 1'b1;
                wr_addr = node_reg;
                wr_data = v_reg;
            end
            else
            begin
                rd_a_en   = 1'b1;
                rd_a_addr = lc[ADDR_W-1:0];
                rd_b_en   = 1'b1;
                rd_b_addr = rc_ok ? rc[ADDR_W-1:0] : lc[ADDR_W-1:0];
            end
        end
        if (cmd.sift_cmp)
        begin
            wr_en   = 1'b1;
            wr_addr = node_reg;
            wr_data = move ? best_val : v_reg;
        end
        if (cmd.extr_rd)
        begin
            rd_a_en   = 1'b1;
            rd_a_addr = '0;
            rd_b_en   = 1'b1;
            rd_b_addr = k_addr;
        end
        if (cmd.extr_swap)
        begin
            wr_en   = 1'b1;
            wr_addr = k_addr;
            wr_data = rd_a_reg;
        end
        if (cmd.out_first)
        begin
            rd_a_en   = 1'b1;
            rd_a_addr = '0;
        end
        if (cmd.out_adv && !out_last)
        begin
            rd_a_en   = 1'b1;
            rd_a_addr = idx_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_a_en)
        begin
            rd_a_reg <= mem[rd_a_addr];
        end
        if (rd_b_en)
        begin
            rd_b_reg <= mem[rd_b_addr];
        end
        v_reg <= v_next;
    end

    always_comb
    begin
        v_next        = v_reg;
        count_next    = count_reg;
        dropped_next  = dropped_reg;
        k_next        = k_reg;
        heap_len_next = heap_len_reg;
        node_next     = node_reg;
        idx_next      = idx_reg;
        rc_ok_next    = rc_ok_reg;
        if (cmd.load)
        begin
            if (full)
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                count_next = count_inc;
            end
            if (in_data.last_element)
            begin
                k_next = (full ? count_reg : count_inc) >> 1;
            end
        end
        if (cmd.build_rd)
        begin
            node_next = k_addr;
            k_next    = k_dec;
        end
        if (cmd.build_fetch)
        begin
            v_next        = rd_a_reg;
            heap_len_next = count_reg;
        end
        if (cmd.sift_rd)
        begin
            rc_ok_next = rc_ok;
        end
        if (cmd.sift_cmp && move)
        begin
            node_next = best_idx;
        end
        if (cmd.extr_init)
        begin
            k_next = count_reg;
        end
        if (cmd.extr_swap)
        begin
            v_next        = rd_b_reg;
            node_next     = '0;
            heap_len_next = k_dec;
            k_next        = k_dec;
        end
        if (cmd.out_first)
        begin
            idx_next = '0;
        end
        if (cmd.out_adv)
        begin
            if (out_last)
            begin
                count_next   = '0;
                dropped_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            dropped_reg  <= 1'b0;
            k_reg        <= '0;
            heap_len_reg <= '0;
            node_reg     <= '0;
            idx_reg      <= '0;
            rc_ok_reg    <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            dropped_reg  <= dropped_next;
            k_reg        <= k_next;
            heap_len_reg <= heap_len_next;
            node_reg     <= node_next;
            idx_reg      <= idx_next;
            rc_ok_reg    <= rc_ok_next;
        end
    end

    assign ext_out = EXT_W'(rd_a_reg);

    assign status.k_zero   = (k_reg == '0);
    assign status.k_le1    = (k_reg <= CNT_W'(1));
    assign status.leaf     = leaf;
    assign status.move     = move;
    assign status.out_last = out_last;

    assign out_data.sorted_value  = ext_out[hs_pkg::FIELD_W-1:0];
    assign out_data.last_result   = out_last;
    assign out_data.overflow_flag = dropped_reg;

    `HS_ASSERT(a_count_in_range, 1'b1, count_reg <= CAP_CNT)
    `HS_ASSERT(a_sift_node_in_heap, cmd.sift_rd, CNT_W'(node_reg) < heap_len_reg)
    `HS_ASSERT_NEXT(a_load_counts, cmd.load && !full, count_reg == $past(count_inc))

endmodule

// ----- rtl/core/hs_ctrl.sv -----
// Controller of the heap sorter: sequences load, heapify, extract, output.
// Depends on hs_pkg and heap_sorter_core_assert.svh.
`include "heap_sorter_core_assert.svh"

module hs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_last,
    input  logic               out_ready,
    input  hs_pkg::hs_status_t status,
    output logic               in_ready,
    output logic               out_valid,
    output hs_pkg::hs_cmd_t    cmd
);

    typedef enum logic [7:0] {
        ST_LOAD        = 8'b0000_0001,
        ST_BUILD_NEXT  = 8'b0000_0010,
        ST_BUILD_FETCH = 8'b0000_0100,
        ST_SIFT_RD     = 8'b0000_1000,
        ST_SIFT_CMP    = 8'b0001_0000,
        ST_EXTR_NEXT   = 8'b0010_0000,
        ST_EXTR_SWAP   = 8'b0100_0000,
        ST_OUT_SEND    = 8'b1000_0000
    } hs_state_t;

    hs_state_t state_reg, state_next;
    logic      extract_reg, extract_next;
    hs_state_t sift_ret;

    // Where a finished sift hands back control.
    assign sift_ret = extract_reg ? ST_EXTR_NEXT : ST_BUILD_NEXT;

    always_comb
    begin
        state_next   = state_reg;
        extract_next = extract_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                if (in_valid && in_last)
                begin
                    extract_next = 1'b0;
                    state_next   = ST_BUILD_NEXT;
                end
            end
            ST_BUILD_NEXT:
            begin
                if (status.k_zero)
                begin
                    cmd.extr_init = 1'b1;
                    extract_next  = 1'b1;
                    state_next    = ST_EXTR_NEXT;
                end
                else
                begin
                    cmd.build_rd = 1'b1;
                    state_next   = ST_BUILD_FETCH;
                end
            end
            ST_BUILD_FETCH:
            begin
                cmd.build_fetch = 1'b1;
                state_next      = ST_SIFT_RD;
            end
            ST_SIFT_RD:
            begin
                cmd.sift_rd = 1'b1;
                state_next  = status.leaf ? sift_ret : ST_SIFT_CMP;
            end
            ST_SIFT_CMP:
            begin
                cmd.sift_cmp = 1'b1;
                state_next   = status.move ? ST_SIFT_RD : sift_ret;
            end
            ST_EXTR_NEXT:
            begin
                if (status.k_le1)
                begin
                    cmd.out_first = 1'b1;
                    state_next    = ST_OUT_SEND;
                end
                else
                begin
                    cmd.extr_rd = 1'b1;
                    state_next  = ST_EXTR_SWAP;
                end
            end
            ST_EXTR_SWAP:
            begin
                cmd.extr_swap = 1'b1;
                state_next    = ST_SIFT_RD;
            end
            ST_OUT_SEND:
            begin
                out_valid   = 1'b1;
                cmd.out_adv = out_ready;
                if (out_ready && status.out_last)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            extract_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            extract_reg <= extract_next;
        end
    end

    `HS_ASSERT(a_one_side_open, 1'b1, !(in_ready && out_valid))
    `HS_ASSERT_NEXT(a_run_ends_in_load, out_valid && out_ready && status.out_last, in_ready)
    `HS_ASSERT_NEXT(a_last_starts_sort, in_valid && in_ready && in_last, !in_ready && !out_valid)

endmodule
